// ----- rtl/core/joystick_axis_conditioner_macros.svh -----
// Assertion macros shared by the joystick axis conditioner checkers.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef JOYSTICK_AXIS_CONDITIONER_MACROS_SVH
`define JOYSTICK_AXIS_CONDITIONER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define JAC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define JAC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/jac_pkg.sv -----
// Shared types and constants for the joystick axis conditioner.
// No dependencies; imported by every module of the block but jac_checker.
`default_nettype none

package jac_pkg;

    localparam int PCT_FULL    = 100;
    localparam int RAW_BITS    = 16;
    localparam int MAG_BITS    = 17;
    localparam int PCT_BITS    = 7;
    localparam int DZ_BITS     = 6;
    localparam int NSTAGE      = 6;
    localparam int PADDR_BITS  = 5;
    localparam int REG_IDX_BITS = 3;

    localparam logic [PCT_BITS-1:0] PCT_MAX = 7'd100;

    // commands carried in tuser
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_CENTER = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_BITS-1:0] REG_DEAD_ZONE  = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_RUDDER_EN  = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_THROT_EN   = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_X_DIR      = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_Y_DIR      = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_RUDDER_DIR = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_THROT_REV  = 3'd6;

    // centered axis slots
    localparam int AX_X      = 0;
    localparam int AX_Y      = 1;
    localparam int AX_RUDDER = 2;

    typedef logic [NSTAGE-1:0] jac_stage_en_t;

    typedef struct packed {
        logic [DZ_BITS-1:0] dead_zone;
        logic               rudder_en;
        logic               throttle_en;
        logic signed [1:0]  x_dir;
        logic signed [1:0]  y_dir;
        logic signed [1:0]  rudder_dir;
        logic               throttle_rev;
    } jac_cfg_t;

    typedef struct packed {
        logic                neg;
        logic [MAG_BITS-1:0] mag;
    } jac_mag_t;

endpackage

`default_nettype wire

// ----- rtl/core/jac_cfg.sv -----
// APB-style register file for the axis conditioner settings.
// Depends on jac_pkg.
`default_nettype none

module jac_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [jac_pkg::PADDR_BITS-1:0]  paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready,
    output jac_pkg::jac_cfg_t                    cfg
);
    import jac_pkg::*;

    jac_cfg_t                cfg_reg;
    jac_cfg_t                cfg_next;
    logic [REG_IDX_BITS-1:0] reg_idx;
    logic                    wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_BITS-1:2];
    assign wr_en   = psel & penable & pwrite & pready;

    always_comb begin
        cfg_next = cfg_reg;
        case (reg_idx)
            REG_DEAD_ZONE:  cfg_next.dead_zone    = pwdata[DZ_BITS-1:0];
            REG_RUDDER_EN:  cfg_next.rudder_en    = pwdata[0];
            REG_THROT_EN:   cfg_next.throttle_en  = pwdata[0];
            REG_X_DIR:      cfg_next.x_dir        = pwdata[1:0];
            REG_Y_DIR:      cfg_next.y_dir        = pwdata[1:0];
            REG_RUDDER_DIR: cfg_next.rudder_dir   = pwdata[1:0];
            REG_THROT_REV:  cfg_next.throttle_rev = pwdata[0];
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dead_zone    <= 6'd3;
            cfg_reg.rudder_en    <= 1'b0;
            cfg_reg.throttle_en  <= 1'b0;
            cfg_reg.x_dir        <= 2'sb01;
            cfg_reg.y_dir        <= 2'sb01;
            cfg_reg.rudder_dir   <= 2'sb01;
            cfg_reg.throttle_rev <= 1'b0;
        end else if (wr_en) begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DEAD_ZONE:  prdata = {26'd0, cfg_reg.dead_zone};
            REG_RUDDER_EN:  prdata = {31'd0, cfg_reg.rudder_en};
            REG_THROT_EN:   prdata = {31'd0, cfg_reg.throttle_en};
            REG_X_DIR:      prdata = {30'd0, cfg_reg.x_dir};
            REG_Y_DIR:      prdata = {30'd0, cfg_reg.y_dir};
            REG_RUDDER_DIR: prdata = {30'd0, cfg_reg.rudder_dir};
            REG_THROT_REV:  prdata = {31'd0, cfg_reg.throttle_rev};
            default:        prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/core/jac_center.sv -----
// Center offset store and first pipeline stage: centered difference and magnitude
// for x, y and rudder. Depends on jac_pkg.
`default_nettype none

module jac_center (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   accept,
    input  wire logic                                   load_en,
    input  wire logic [1:0]                             command,
    input  wire logic signed [jac_pkg::RAW_BITS-1:0]    raw_x,
    input  wire logic signed [jac_pkg::RAW_BITS-1:0]    raw_y,
    input  wire logic signed [jac_pkg::RAW_BITS-1:0]    raw_rudder,
    input  wire logic                                   rudder_en,
    output jac_pkg::jac_mag_t [2:0]                     mag
);
    import jac_pkg::*;

    logic signed [RAW_BITS-1:0] off_reg  [3];
    logic signed [RAW_BITS-1:0] raw_axis [3];
    logic signed [MAG_BITS-1:0] diff     [3];
    jac_mag_t [2:0]             mag_reg;
    jac_mag_t [2:0]             mag_next;

    assign raw_axis[AX_X]      = raw_x;
    assign raw_axis[AX_Y]      = raw_y;
    assign raw_axis[AX_RUDDER] = raw_rudder;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg[AX_X]      <= '0;
            off_reg[AX_Y]      <= '0;
            off_reg[AX_RUDDER] <= '0;
        end else if (accept) begin
            case (command)
                CMD_CENTER: begin
                    off_reg[AX_X]      <= raw_x;
                    off_reg[AX_Y]      <= raw_y;
                    off_reg[AX_RUDDER] <= rudder_en ? raw_rudder : '0;
                end
                CMD_CLEAR: begin
                    off_reg[AX_X]      <= '0;
                    off_reg[AX_Y]      <= '0;
                    off_reg[AX_RUDDER] <= '0;
                end
                default: ;
            endcase
        end
    end

    // 17-bit difference never wraps; its magnitude fits 17 bits unsigned
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff[i] = {raw_axis[i][RAW_BITS-1], raw_axis[i]}
                    - {off_reg[i][RAW_BITS-1], off_reg[i]};
            mag_next[i].neg = diff[i][MAG_BITS-1];
            mag_next[i].mag = diff[i][MAG_BITS-1] ? (~diff[i] + 1'b1) : diff[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            mag_reg <= mag_next;
        end
    end

    assign mag = mag_reg;

endmodule

`default_nettype wire

// ----- rtl/core/jac_scale.sv -----
// Two-stage truncating scale to percent: floor(mag * 100 / (2^DIV_BITS - 1)),
// saturated at 100. Reciprocal multiply plus one-step correction. Depends on jac_pkg.
`default_nettype none

module jac_scale #(
    parameter int DIV_BITS = 15
) (
    input  wire logic                              aclk,
    input  wire logic [1:0]                        en,
    input  wire logic [jac_pkg::MAG_BITS-1:0]      mag,
    output logic      [jac_pkg::PCT_BITS-1:0]      pct
);
    import jac_pkg::*;

    localparam int unsigned DIVISOR  = (32'd1 << DIV_BITS) - 32'd1;
    localparam int          SHIFT    = DIV_BITS + 8;
    localparam int unsigned RECIP    = (32'd1 << SHIFT) / DIVISOR;
    localparam int unsigned SCALE_K  = RECIP * PCT_FULL;
    localparam int          K_BITS   = $clog2(SCALE_K + 1);
    localparam int          PROD_BITS = MAG_BITS + K_BITS;
    localparam int          NUM_BITS = MAG_BITS + PCT_BITS;

    logic [PROD_BITS-1:0] prod;
    logic [NUM_BITS-1:0]  num_next;
    logic [NUM_BITS-1:0]  num_reg;
    logic [PCT_BITS-1:0]  q0_reg;
    logic                 sat_reg;
    logic [NUM_BITS-1:0]  back;
    logic [NUM_BITS-1:0]  rem;
    logic [PCT_BITS-1:0]  q;
    logic [PCT_BITS-1:0]  pct_next;
    logic [PCT_BITS-1:0]  pct_reg;

    // estimate is exact or one low whenever the result is below 100
    assign prod     = PROD_BITS'(mag) * PROD_BITS'(SCALE_K);
    assign num_next = NUM_BITS'(mag) * NUM_BITS'(PCT_FULL);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            num_reg <= num_next;
            q0_reg  <= prod[SHIFT +: PCT_BITS];
            sat_reg <= (mag >= MAG_BITS'(DIVISOR));
        end
    end

    assign back     = NUM_BITS'(q0_reg) * NUM_BITS'(DIVISOR);
    assign rem      = num_reg - back;
    assign q        = q0_reg + PCT_BITS'(rem >= NUM_BITS'(DIVISOR));
    assign pct_next = sat_reg ? PCT_MAX : q;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            pct_reg <= pct_next;
        end
    end

    assign pct = pct_reg;

endmodule

`default_nettype wire

// ----- rtl/core/jac_axis.sv -----
// Centered axis path, stages 2 to 6: percent scale, dead zone with rescale
// (two-stage restoring divide), sign and direction. Depends on jac_pkg, jac_scale.
`default_nettype none

module jac_axis #(
    parameter int AXIS_BITS = 16
) (
    input  wire logic                              aclk,
    input  wire jac_pkg::jac_stage_en_t            stage_en,
    input  wire jac_pkg::jac_mag_t                 mag_in,
    input  wire logic [jac_pkg::DZ_BITS-1:0]       dead_zone,
    input  wire logic signed [1:0]                 dir,
    input  wire logic                              negate,
    input  wire logic                              axis_en,
    output logic signed [7:0]                      pos
);
    import jac_pkg::*;

    localparam int NUM_BITS = 14;

    logic [PCT_BITS-1:0]    pct;
    logic                   neg_s2_reg;
    logic                   neg_s3_reg;
    logic                   neg_s4_reg;

    logic [PCT_BITS-1:0]    dz_ext;
    logic                   zone;
    logic [PCT_BITS-1:0]    span;
    logic [PCT_BITS-1:0]    den;
    logic [NUM_BITS-1:0]    num;
    logic [NUM_BITS-1:0]    rem_a;
    logic [NUM_BITS-1:0]    trial_a;
    logic [3:0]             qhi;

    logic [NUM_BITS-1:0]    rem_s4_reg;
    logic [3:0]             qhi_s4_reg;
    logic [PCT_BITS-1:0]    den_s4_reg;
    logic                   zone_s4_reg;

    logic [NUM_BITS-1:0]    rem_b;
    logic [NUM_BITS-1:0]    trial_b;
    logic [2:0]             qlo;
    logic [PCT_BITS-1:0]    mag_pct;
    logic signed [7:0]      sw_next;
    logic signed [7:0]      sw_s5_reg;

    logic signed [2:0]      dir3;
    logic signed [2:0]      fac;
    logic signed [10:0]     prod;
    logic signed [7:0]      pos_next;
    logic signed [7:0]      pos_reg;

    jac_scale #(.DIV_BITS(AXIS_BITS - 1)) u_scale (
        .aclk (aclk),
        .en   (stage_en[2:1]),
        .mag  (mag_in.mag),
        .pct  (pct)
    );

    always_ff @(posedge aclk) begin
        if (stage_en[1]) neg_s2_reg <= mag_in.neg;
        if (stage_en[2]) neg_s3_reg <= neg_s2_reg;
    end

    // stage 4: dead zone test and upper quotient bits
    assign dz_ext = PCT_BITS'(dead_zone);
    assign zone   = (pct <= dz_ext);
    assign span   = pct - dz_ext;
    assign den    = PCT_MAX - dz_ext;
    assign num    = NUM_BITS'(span) * NUM_BITS'(PCT_FULL);

    always_comb begin
        rem_a   = num;
        qhi     = '0;
        trial_a = '0;
        for (int i = 3; i >= 0; i--) begin
            trial_a = NUM_BITS'(den) << (i + 3);
            if (rem_a >= trial_a) begin
                rem_a  = rem_a - trial_a;
                qhi[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            rem_s4_reg  <= rem_a;
            qhi_s4_reg  <= qhi;
            den_s4_reg  <= den;
            zone_s4_reg <= zone;
            neg_s4_reg  <= neg_s3_reg;
        end
    end

    // stage 5: lower quotient bits and sign
    always_comb begin
        rem_b   = rem_s4_reg;
        qlo     = '0;
        trial_b = '0;
        for (int i = 2; i >= 0; i--) begin
            trial_b = NUM_BITS'(den_s4_reg) << i;
            if (rem_b >= trial_b) begin
                rem_b  = rem_b - trial_b;
                qlo[i] = 1'b1;
            end
        end
    end

    assign mag_pct = zone_s4_reg ? '0 : {qhi_s4_reg, qlo};
    assign sw_next = neg_s4_reg ? (8'sd0 - $signed({1'b0, mag_pct}))
                                : $signed({1'b0, mag_pct});

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            sw_s5_reg <= sw_next;
        end
    end

    // stage 6: direction factor (-2..2), clamp and axis enable
    assign dir3 = {dir[1], dir};
    assign fac  = negate ? (3'sd0 - dir3) : dir3;
    assign prod = $signed({{8{fac[2]}}, fac}) * $signed({{3{sw_s5_reg[7]}}, sw_s5_reg});

    always_comb begin
        priority if (!axis_en) begin
            pos_next = 8'sd0;
        end else if (prod > 11'sd100) begin
            pos_next = 8'sd100;
        end else if (prod < -11'sd100) begin
            pos_next = -8'sd100;
        end else begin
            pos_next = prod[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[5]) begin
            pos_reg <= pos_next;
        end
    end

    assign pos = pos_reg;

endmodule

`default_nettype wire

// ----- rtl/core/jac_throttle.sv -----
// Throttle path, stages 1 to 6: offset from axis minimum, percent scale,
// reversal and end dead zones. Depends on jac_pkg, jac_scale.
`default_nettype none

module jac_throttle #(
    parameter int AXIS_BITS = 16
) (
    input  wire logic                                aclk,
    input  wire jac_pkg::jac_stage_en_t              stage_en,
    input  wire logic signed [jac_pkg::RAW_BITS-1:0] raw_throttle,
    input  wire logic [jac_pkg::DZ_BITS-1:0]         dead_zone,
    input  wire logic                                reverse,
    input  wire logic                                axis_en,
    output logic [jac_pkg::PCT_BITS-1:0]             pos
);
    import jac_pkg::*;

    localparam int OFS_BITS = MAG_BITS + 1;

    logic signed [OFS_BITS-1:0] ofs;
    jac_mag_t                   t_s1_reg;
    logic                       neg_s2_reg;
    logic                       neg_s3_reg;
    logic [PCT_BITS-1:0]        pct;

    logic [PCT_BITS-1:0]        dz_ext;
    logic [PCT_BITS-1:0]        v0;
    logic [PCT_BITS-1:0]        v1;
    logic [PCT_BITS-1:0]        hi;
    logic [PCT_BITS-1:0]        v_next;
    logic [PCT_BITS-1:0]        v_s4_reg;
    logic [PCT_BITS-1:0]        v_s5_reg;
    logic [PCT_BITS-1:0]        pos_reg;

    // raw minus the axis minimum; negative only when AXIS_BITS is below 16
    assign ofs = {{(OFS_BITS-RAW_BITS){raw_throttle[RAW_BITS-1]}}, raw_throttle}
               + OFS_BITS'(32'd1 << (AXIS_BITS - 1));

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            t_s1_reg.neg <= ofs[OFS_BITS-1];
            t_s1_reg.mag <= ofs[MAG_BITS-1:0];
        end
    end

    jac_scale #(.DIV_BITS(AXIS_BITS)) u_scale (
        .aclk (aclk),
        .en   (stage_en[2:1]),
        .mag  (t_s1_reg.mag),
        .pct  (pct)
    );

    always_ff @(posedge aclk) begin
        if (stage_en[1]) neg_s2_reg <= t_s1_reg.neg;
        if (stage_en[2]) neg_s3_reg <= neg_s2_reg;
    end

    // lower dead zone wins over upper
    assign dz_ext = PCT_BITS'(dead_zone);
    assign v0     = neg_s3_reg ? '0 : pct;
    assign v1     = reverse ? (PCT_MAX - v0) : v0;
    assign hi     = PCT_MAX - dz_ext;

    always_comb begin
        priority if (v1 <= dz_ext) begin
            v_next = '0;
        end else if (v1 >= hi) begin
            v_next = PCT_MAX;
        end else begin
            v_next = v1;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[3]) v_s4_reg <= v_next;
        if (stage_en[4]) v_s5_reg <= v_s4_reg;
        if (stage_en[5]) pos_reg  <= axis_en ? v_s5_reg : '0;
    end

    assign pos = pos_reg;

endmodule

`default_nettype wire

// ----- rtl/core/joystick_axis_conditioner.sv -----
// Channel   | Dir | Payload
// s_ stream | in  | tdata: raw_x, raw_y, raw_rudder, raw_throttle; tuser: command
// m_ stream | out | tdata: pos_x, pos_y, pos_rudder, pos_throttle
// APB       | in  | seven settings registers at 4-byte steps
//
// Six register stages; an accepted sample beat passes through all six to reach m_.
// One beat per cycle while m_tready is high; center and clear beats update the
// offsets at the accepting edge and produce no output. Each stage holds a valid
// bit and empty stages fill while the output is stalled. aresetn (synchronous)
// clears valid bits, offsets and settings. Depends on jac_pkg and all jac_* modules.
`default_nettype none

module joystick_axis_conditioner #(
    parameter int AXIS_BITS = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [jac_pkg::PADDR_BITS-1:0]    paddr,
    input  wire logic [31:0]                       pwdata,
    output logic      [31:0]                       prdata,
    output logic                                   pready,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // raw_x[15:0], raw_y[31:16], raw_rudder[47:32], raw_throttle[63:48]
    input  wire logic [63:0]                       s_tdata,
    // command[1:0]
    input  wire logic [1:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // pos_x[7:0], pos_y[15:8], pos_rudder[23:16], pos_throttle[30:24], zero[31]
    output logic [31:0]                            m_tdata
);
    import jac_pkg::*;

    jac_cfg_t            cfg;
    jac_stage_en_t       stage_en;
    logic [NSTAGE-1:0]   v_reg;
    logic [NSTAGE-1:0]   v_next;
    logic                accept;
    jac_mag_t [2:0]      mag;
    logic signed [7:0]   pos_x;
    logic signed [7:0]   pos_y;
    logic signed [7:0]   pos_rudder;
    logic [PCT_BITS-1:0] pos_throttle;

    jac_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // a stage loads when it is empty or the stage after it loads
    always_comb begin
        stage_en[NSTAGE-1] = !v_reg[NSTAGE-1] || m_tready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            stage_en[k] = !v_reg[k] || stage_en[k+1];
        end
    end

    assign s_tready = stage_en[0];
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        v_next = v_reg;
        if (stage_en[0]) v_next[0] = accept && (s_tuser == CMD_SAMPLE);
        for (int k = 1; k < NSTAGE; k++) begin
            if (stage_en[k]) v_next[k] = v_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    jac_center u_center (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .load_en    (stage_en[0]),
        .command    (s_tuser),
        .raw_x      (s_tdata[15:0]),
        .raw_y      (s_tdata[31:16]),
        .raw_rudder (s_tdata[47:32]),
        .rudder_en  (cfg.rudder_en),
        .mag        (mag)
    );

    jac_axis #(.AXIS_BITS(AXIS_BITS)) u_axis_x (
        .aclk      (aclk),
        .stage_en  (stage_en),
        .mag_in    (mag[AX_X]),
        .dead_zone (cfg.dead_zone),
        .dir       (cfg.x_dir),
        .negate    (1'b1),
        .axis_en   (1'b1),
        .pos       (pos_x)
    );

    jac_axis #(.AXIS_BITS(AXIS_BITS)) u_axis_y (
        .aclk      (aclk),
        .stage_en  (stage_en),
        .mag_in    (mag[AX_Y]),
        .dead_zone (cfg.dead_zone),
        .dir       (cfg.y_dir),
        .negate    (1'b0),
        .axis_en   (1'b1),
        .pos       (pos_y)
    );

    jac_axis #(.AXIS_BITS(AXIS_BITS)) u_axis_rudder (
        .aclk      (aclk),
        .stage_en  (stage_en),
        .mag_in    (mag[AX_RUDDER]),
        .dead_zone (cfg.dead_zone),
        .dir       (cfg.rudder_dir),
        .negate    (1'b0),
        .axis_en   (cfg.rudder_en),
        .pos       (pos_rudder)
    );

    jac_throttle #(.AXIS_BITS(AXIS_BITS)) u_throttle (
        .aclk         (aclk),
        .stage_en     (stage_en),
        .raw_throttle (s_tdata[63:48]),
        .dead_zone    (cfg.dead_zone),
        .reverse      (cfg.throttle_rev),
        .axis_en      (cfg.throttle_en),
        .pos          (pos_throttle)
    );

    assign m_tvalid = v_reg[NSTAGE-1];
    assign m_tdata  = {1'b0, pos_throttle, pos_rudder, pos_y, pos_x};

endmodule

`default_nettype wire

// ----- rtl/core/jac_checker.sv -----
// Port-level checker for the joystick axis conditioner, bound to the top level.
// Depends on joystick_axis_conditioner_macros.svh.
`default_nettype none

`include "joystick_axis_conditioner_macros.svh"

module jac_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // an empty output stage means the whole pipe can move
    `JAC_ASSERT_NOW(a_backpressure_only_when_full, aclk, aresetn, !s_tready, m_tvalid, "input stalled while output empty")

    `JAC_ASSERT_NOW(a_axes_in_range, aclk, aresetn, m_tvalid, ($signed(m_tdata[7:0]) >= -8'sd100) && ($signed(m_tdata[7:0]) <= 8'sd100) && ($signed(m_tdata[15:8]) >= -8'sd100) && ($signed(m_tdata[15:8]) <= 8'sd100) && ($signed(m_tdata[23:16]) >= -8'sd100) && ($signed(m_tdata[23:16]) <= 8'sd100), "axis position beyond +-100")

    `JAC_ASSERT_NOW(a_throttle_in_range, aclk, aresetn, m_tvalid, (m_tdata[30:24] <= 7'd100) && !m_tdata[31], "throttle beyond 100 or pad bit set")

    `JAC_ASSERT_NEXT(a_stalled_beat_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled output beat changed")

endmodule

bind joystick_axis_conditioner jac_checker u_checker (.*);

`default_nettype wire
